// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Operation codes, controller commands, status codes and common helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int INT_W = 32;
    localparam int DW    = 2 * INT_W;
    localparam int CW    = $clog2(DW);

    localparam logic [DW-1:0] LIM = DW'(1) << (INT_W - 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REC = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;
    localparam logic [2:0] OP_RED = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE    = 4'd0;
    localparam t_cmd CMD_LOAD    = 4'd1;
    localparam t_cmd CMD_GCD_DEN = 4'd2;
    localparam t_cmd CMD_DIV_DEN = 4'd3;
    localparam t_cmd CMD_MUL0    = 4'd4;
    localparam t_cmd CMD_MUL1    = 4'd5;
    localparam t_cmd CMD_MUL2    = 4'd6;
    localparam t_cmd CMD_ADD     = 4'd7;
    localparam t_cmd CMD_GCD_RES = 4'd8;
    localparam t_cmd CMD_DIV_RES = 4'd9;
    localparam t_cmd CMD_TAKE_Q  = 4'd10;
    localparam t_cmd CMD_FINISH  = 4'd11;

    typedef struct packed {
        logic err;
        logic is_cmp;
        logic is_addsub;
        logic is_muldiv;
        logic x_zero;
        logic gcd_done;
        logic div_done;
    } t_sts;

    function automatic logic [INT_W-1:0] mag_of(input logic [INT_W-1:0] v);
        mag_of = v[INT_W-1] ? (~v + INT_W'(1)) : v;
    endfunction

endpackage

// ===== hw/rtl/rau_gcd.sv =====
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary greatest common divisor
// One shift or subtract-and-shift step per cycle on two non-zero operands.
// ----------------------------------------------------------------------------
module rau_gcd (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rau_pkg::DW-1:0]   i_x,
    input  logic [rau_pkg::DW-1:0]   i_y,
    output logic                     o_done,
    output logic [rau_pkg::DW-1:0]   o_g
);

    logic                   r_busy;
    logic                   r_done;
    logic [rau_pkg::DW-1:0] r_u;
    logic [rau_pkg::DW-1:0] r_v;
    logic [rau_pkg::CW-1:0] r_k;
    logic [rau_pkg::DW-1:0] r_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_u    <= i_x;
                r_v    <= i_y;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_u == r_v) begin
                    r_g    <= r_u << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + rau_pkg::CW'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= (r_u - r_v) >> 1;
                end else begin
                    r_v <= (r_v - r_u) >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("gcd done while still busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_u != r_v) |=> !r_done)
        else $error("gcd finished before operands met");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_g != '0)
        else $error("gcd result is zero");

endmodule

// ===== hw/rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: two-lane restoring divider
// Divides two dividends by one common divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rau_pkg::DW-1:0]   i_n0,
    input  logic [rau_pkg::DW-1:0]   i_n1,
    input  logic [rau_pkg::DW-1:0]   i_d,
    output logic                     o_done,
    output logic [rau_pkg::DW-1:0]   o_q0,
    output logic [rau_pkg::DW-1:0]   o_q1
);

    logic                   r_busy;
    logic                   r_done;
    logic [rau_pkg::CW-1:0] r_cnt;
    logic [rau_pkg::DW-1:0] r_d;
    logic [rau_pkg::DW-1:0] r_q0;
    logic [rau_pkg::DW-1:0] r_q1;
    logic [rau_pkg::DW-1:0] r_r0;
    logic [rau_pkg::DW-1:0] r_r1;

    logic [rau_pkg::DW:0]   w_t0;
    logic [rau_pkg::DW:0]   w_t1;
    logic [rau_pkg::DW:0]   w_s0;
    logic [rau_pkg::DW:0]   w_s1;
    logic                   w_ge0;
    logic                   w_ge1;

    always_comb begin
        w_t0  = {r_r0, r_q0[rau_pkg::DW-1]};
        w_t1  = {r_r1, r_q1[rau_pkg::DW-1]};
        w_ge0 = w_t0 >= {1'b0, r_d};
        w_ge1 = w_t1 >= {1'b0, r_d};
        w_s0  = w_ge0 ? (w_t0 - {1'b0, r_d}) : w_t0;
        w_s1  = w_ge1 ? (w_t1 - {1'b0, r_d}) : w_t1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_d    <= i_d;
                r_q0   <= i_n0;
                r_q1   <= i_n1;
                r_r0   <= '0;
                r_r1   <= '0;
            end else if (r_busy) begin
                r_r0  <= w_s0[rau_pkg::DW-1:0];
                r_r1  <= w_s1[rau_pkg::DW-1:0];
                r_q0  <= {r_q0[rau_pkg::DW-2:0], w_ge0};
                r_q1  <= {r_q1[rau_pkg::DW-2:0], w_ge1};
                r_cnt <= r_cnt - rau_pkg::CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q0   = r_q0;
    assign o_q1   = r_q1;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt != '0) |=> r_busy)
        else $error("divider stopped early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_r0 < r_d || r_d == '0)
        else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Operand registers, one shared multiplier, the GCD and divider units and
// the result register, all steered by controller commands.
// ----------------------------------------------------------------------------
module rau_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rau_pkg::t_cmd         i_cmd,
    input  logic [2:0]            i_opcode,
    input  logic [31:0]           i_a_num,
    input  logic [31:0]           i_a_den,
    input  logic [31:0]           i_b_num,
    input  logic [31:0]           i_b_den,
    output rau_pkg::t_sts         o_sts,
    output logic [31:0]           o_res_num,
    output logic [30:0]           o_res_den,
    output logic                  o_is_greater,
    output logic                  o_is_less,
    output logic [1:0]            o_status
);

    localparam int W  = rau_pkg::INT_W;
    localparam int DW = rau_pkg::DW;

    logic [2:0]    r_op;
    logic          r_err;
    logic          r_a_neg;
    logic          r_b_neg;
    logic          r_neg;
    logic [W-1:0]  r_an;
    logic [W-1:0]  r_ad;
    logic [W-1:0]  r_bn;
    logic [W-1:0]  r_bd;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_t;

    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;
    logic          r_gt;
    logic          r_lt;
    logic [1:0]    r_status;

    // Load-time decode of the raw operands.
    logic [W-1:0]  w_an;
    logic [W-1:0]  w_ad;
    logic [W-1:0]  w_bn;
    logic [W-1:0]  w_bd;
    logic [2:0]    w_op;
    logic          w_uses_b;
    logic          w_err;
    logic          w_a_neg;
    logic          w_b_neg;

    logic          w_addsub;
    logic [W-1:0]  w_ma;
    logic [W-1:0]  w_mb;
    logic [DW-1:0] w_prod;

    logic          w_nb;
    logic [DW-1:0] w_sum;
    logic          w_sum_neg;

    logic          w_gcd_start;
    logic [DW-1:0] w_gx;
    logic [DW-1:0] w_gy;
    logic          w_gcd_done;
    logic [DW-1:0] w_g;
    logic          w_div_start;
    logic [DW-1:0] w_n0;
    logic [DW-1:0] w_n1;
    logic          w_div_done;
    logic [DW-1:0] w_q0;
    logic [DW-1:0] w_q1;

    logic          w_ovf;
    logic [W-1:0]  w_num;
    logic [DW-1:0] w_pa;
    logic [DW-1:0] w_pb;

    always_comb begin
        w_an     = i_a_num[W-1:0];
        w_ad     = i_a_den[W-1:0];
        w_bn     = i_b_num[W-1:0];
        w_bd     = i_b_den[W-1:0];
        w_op     = (i_opcode > rau_pkg::OP_RED) ? rau_pkg::OP_RED : i_opcode;
        w_uses_b = (w_op <= rau_pkg::OP_DIV) || (w_op == rau_pkg::OP_CMP);
        w_err    = (w_ad == '0) || (w_uses_b && w_bd == '0)
                || (w_op == rau_pkg::OP_DIV && w_bn == '0)
                || (w_op == rau_pkg::OP_REC && w_an == '0);
        w_a_neg  = (w_an != '0) && (w_an[W-1] ^ w_ad[W-1]);
        w_b_neg  = (w_bn != '0) && (w_bn[W-1] ^ w_bd[W-1]);
    end

    // Shared multiplier; operands depend on the step and the operation.
    always_comb begin
        w_addsub = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB);
        w_ma     = r_an;
        w_mb     = r_bd;
        case (i_cmd)
            rau_pkg::CMD_MUL0: begin
                if (w_addsub) begin
                    w_ma = w_q0[W-1:0];
                    w_mb = r_bd;
                end else if (r_op == rau_pkg::OP_MUL) begin
                    w_ma = r_an;
                    w_mb = r_bn;
                end
            end
            rau_pkg::CMD_MUL1: begin
                if (w_addsub) begin
                    w_ma = r_an;
                    w_mb = w_q1[W-1:0];
                end else if (r_op == rau_pkg::OP_MUL) begin
                    w_ma = r_ad;
                    w_mb = r_bd;
                end else begin
                    w_ma = r_ad;
                    w_mb = r_bn;
                end
            end
            rau_pkg::CMD_MUL2: begin
                w_ma = r_bn;
                w_mb = w_q0[W-1:0];
            end
            default: begin
                w_ma = r_an;
                w_mb = r_bd;
            end
        endcase
        w_prod = {{W{1'b0}}, w_ma} * {{W{1'b0}}, w_mb};
    end

    // Signed sum of the two scaled numerators held as sign and magnitude.
    always_comb begin
        w_nb = (r_op == rau_pkg::OP_SUB) ? ~r_b_neg : r_b_neg;
        if (r_bn == '0) begin
            w_nb = 1'b0;
        end
        if (r_a_neg == w_nb) begin
            w_sum     = r_t + r_x;
            w_sum_neg = r_a_neg;
        end else if (r_t >= r_x) begin
            w_sum     = r_t - r_x;
            w_sum_neg = r_a_neg;
        end else begin
            w_sum     = r_x - r_t;
            w_sum_neg = w_nb;
        end
    end

    always_comb begin
        w_gcd_start = (i_cmd == rau_pkg::CMD_GCD_DEN) || (i_cmd == rau_pkg::CMD_GCD_RES);
        w_div_start = (i_cmd == rau_pkg::CMD_DIV_DEN) || (i_cmd == rau_pkg::CMD_DIV_RES);
        if (i_cmd == rau_pkg::CMD_GCD_DEN || i_cmd == rau_pkg::CMD_DIV_DEN) begin
            w_gx = DW'(r_ad);
            w_gy = DW'(r_bd);
        end else begin
            w_gx = r_x;
            w_gy = r_y;
        end
        w_n0 = w_gx;
        w_n1 = w_gy;
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (w_gx),
        .i_y     (w_gy),
        .o_done  (w_gcd_done),
        .o_g     (w_g)
    );

    rau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_n0    (w_n0),
        .i_n1    (w_n1),
        .i_d     (w_g),
        .o_done  (w_div_done),
        .o_q0    (w_q0),
        .o_q1    (w_q1)
    );

    always_comb begin
        w_ovf = (r_y > rau_pkg::LIM - DW'(1))
             || (r_x > (r_neg ? rau_pkg::LIM : rau_pkg::LIM - DW'(1)));
        w_num = r_neg ? (~r_x[W-1:0] + W'(1)) : r_x[W-1:0];
        w_pa  = r_a_neg ? (~r_x + DW'(1)) : r_x;
        w_pb  = r_b_neg ? (~r_y + DW'(1)) : r_y;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rau_pkg::CMD_LOAD: begin
                r_op    <= w_op;
                r_err   <= w_err;
                r_a_neg <= w_a_neg;
                r_b_neg <= w_b_neg;
                r_an    <= rau_pkg::mag_of(w_an);
                r_ad    <= rau_pkg::mag_of(w_ad);
                r_bn    <= rau_pkg::mag_of(w_bn);
                r_bd    <= rau_pkg::mag_of(w_bd);
                r_neg   <= (w_op == rau_pkg::OP_MUL || w_op == rau_pkg::OP_DIV)
                         ? (w_a_neg ^ w_b_neg) : w_a_neg;
                if (w_op == rau_pkg::OP_REC) begin
                    r_x <= DW'(rau_pkg::mag_of(w_ad));
                    r_y <= DW'(rau_pkg::mag_of(w_an));
                end else begin
                    r_x <= DW'(rau_pkg::mag_of(w_an));
                    r_y <= DW'(rau_pkg::mag_of(w_ad));
                end
            end
            rau_pkg::CMD_MUL0: begin
                if (w_addsub) begin
                    r_y <= w_prod;
                end else begin
                    r_x <= w_prod;
                end
            end
            rau_pkg::CMD_MUL1: begin
                if (w_addsub) begin
                    r_t <= w_prod;
                end else begin
                    r_y <= w_prod;
                end
            end
            rau_pkg::CMD_MUL2: begin
                r_x <= w_prod;
            end
            rau_pkg::CMD_ADD: begin
                r_x   <= w_sum;
                r_neg <= w_sum_neg;
            end
            rau_pkg::CMD_TAKE_Q: begin
                if (w_div_done) begin
                    r_x <= w_q0;
                    r_y <= w_q1;
                end
            end
            rau_pkg::CMD_FINISH: begin
                r_gt      <= 1'b0;
                r_lt      <= 1'b0;
                r_res_num <= '0;
                r_res_den <= '0;
                if (r_err) begin
                    r_status <= rau_pkg::ST_ZERO;
                end else if (r_op == rau_pkg::OP_CMP) begin
                    r_status <= rau_pkg::ST_OK;
                    r_gt     <= $signed(w_pa) > $signed(w_pb);
                    r_lt     <= $signed(w_pa) < $signed(w_pb);
                end else if (r_x == '0) begin
                    r_status  <= rau_pkg::ST_OK;
                    r_res_den <= 31'd1;
                end else if (w_ovf) begin
                    r_status <= rau_pkg::ST_OVF;
                end else begin
                    r_status  <= rau_pkg::ST_OK;
                    r_res_num <= 32'($signed(w_num));
                    r_res_den <= 31'(r_y[W-2:0]);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.err       = r_err;
        o_sts.is_cmp    = (r_op == rau_pkg::OP_CMP);
        o_sts.is_addsub = w_addsub;
        o_sts.is_muldiv = (r_op == rau_pkg::OP_MUL) || (r_op == rau_pkg::OP_DIV);
        o_sts.x_zero    = (r_x == '0);
        o_sts.gcd_done  = w_gcd_done;
        o_sts.div_done  = w_div_done;
    end

    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_is_greater = r_gt;
    assign o_is_less    = r_lt;
    assign o_status     = r_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd == rau_pkg::CMD_FINISH) |-> !(r_gt && r_lt))
        else $error("compare flags both set");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == rau_pkg::CMD_FINISH && r_err) |=> r_res_den == '0 && !r_gt && !r_lt)
        else $error("error result not cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == rau_pkg::CMD_TAKE_Q && w_div_done && r_x != '0) |=> r_y != '0)
        else $error("reduced denominator is zero");

endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through multiply, GCD and divide phases per request.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_m_tready,
    input  rau_pkg::t_sts  i_sts,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    output rau_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_G1S   = 4'd2;
    localparam logic [3:0] S_G1W   = 4'd3;
    localparam logic [3:0] S_D1S   = 4'd4;
    localparam logic [3:0] S_D1W   = 4'd5;
    localparam logic [3:0] S_M0    = 4'd6;
    localparam logic [3:0] S_M1    = 4'd7;
    localparam logic [3:0] S_M2    = 4'd8;
    localparam logic [3:0] S_ADD   = 4'd9;
    localparam logic [3:0] S_ZCHK  = 4'd10;
    localparam logic [3:0] S_G2S   = 4'd11;
    localparam logic [3:0] S_G2W   = 4'd12;
    localparam logic [3:0] S_D2S   = 4'd13;
    localparam logic [3:0] S_D2W   = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       w_out_free;

    assign w_out_free = !r_ovalid || i_m_tready;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_m_tready;
        o_cmd    = rau_pkg::CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd   = rau_pkg::CMD_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    n_state = S_FIN;
                end else if (i_sts.is_addsub) begin
                    n_state = S_G1S;
                end else if (i_sts.is_cmp || i_sts.is_muldiv) begin
                    n_state = S_M0;
                end else begin
                    n_state = S_ZCHK;
                end
            end
            S_G1S: begin
                o_cmd   = rau_pkg::CMD_GCD_DEN;
                n_state = S_G1W;
            end
            S_G1W: begin
                if (i_sts.gcd_done) begin
                    n_state = S_D1S;
                end
            end
            S_D1S: begin
                o_cmd   = rau_pkg::CMD_DIV_DEN;
                n_state = S_D1W;
            end
            S_D1W: begin
                if (i_sts.div_done) begin
                    n_state = S_M0;
                end
            end
            S_M0: begin
                o_cmd   = rau_pkg::CMD_MUL0;
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd = rau_pkg::CMD_MUL1;
                if (i_sts.is_addsub) begin
                    n_state = S_M2;
                end else if (i_sts.is_cmp) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ZCHK;
                end
            end
            S_M2: begin
                o_cmd   = rau_pkg::CMD_MUL2;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd   = rau_pkg::CMD_ADD;
                n_state = S_ZCHK;
            end
            S_ZCHK: begin
                n_state = i_sts.x_zero ? S_FIN : S_G2S;
            end
            S_G2S: begin
                o_cmd   = rau_pkg::CMD_GCD_RES;
                n_state = S_G2W;
            end
            S_G2W: begin
                if (i_sts.gcd_done) begin
                    n_state = S_D2S;
                end
            end
            S_D2S: begin
                o_cmd   = rau_pkg::CMD_DIV_RES;
                n_state = S_D2W;
            end
            S_D2W: begin
                o_cmd = rau_pkg::CMD_TAKE_Q;
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // The result register is only overwritten once it is free.
                if (w_out_free) begin
                    o_cmd    = rau_pkg::CMD_FINISH;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> r_state == S_CHECK)
        else $error("accepted request not started");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_ovalid && !i_m_tready) |=> r_state == S_FIN)
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// An error goes straight to the finish state and a compare needs only the two
// multiply steps; add and subtract run the GCD and the divider up to twice, and
// multiply, divide, reciprocal and reduce fall in between. The binary GCD unit (one
// step per cycle on 64-bit values) and the two-lane divider set the run time.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken. Synchronous active-low reset.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic with GCD reduction
// Add, subtract, multiply, divide, reciprocal, compare and reduce.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [135:0]  i_s_tdata,   // opcode, a_num, a_den, b_num, b_den, zero pad
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [71:0]   o_m_tdata    // res_num, res_den, is_greater, is_less, status, pad
);

    rau_pkg::t_cmd w_cmd;
    rau_pkg::t_sts w_sts;
    logic [31:0]   w_res_num;
    logic [30:0]   w_res_den;
    logic          w_gt;
    logic          w_lt;
    logic [1:0]    w_status;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    rau_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_opcode     (i_s_tdata[2:0]),
        .i_a_num      (i_s_tdata[34:3]),
        .i_a_den      (i_s_tdata[66:35]),
        .i_b_num      (i_s_tdata[98:67]),
        .i_b_den      (i_s_tdata[130:99]),
        .o_sts        (w_sts),
        .o_res_num    (w_res_num),
        .o_res_den    (w_res_den),
        .o_is_greater (w_gt),
        .o_is_less    (w_lt),
        .o_status     (w_status)
    );

    assign o_m_tdata = {5'd0, w_status, w_lt, w_gt, w_res_den, w_res_num};

endmodule

// ===== bench/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker: result predictor and scoreboard for the rational arithmetic unit
// Watches both stream channels, works out the expected result of every
// accepted request and compares each returned result field by field.
// ----------------------------------------------------------------------------
module rau_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        gt;
        logic        lt;
        logic [1:0]  st;
    } t_res;

    t_res expected_q[$];
    int   errors = 0;

    assign o_errors = errors;

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [63:0] abs64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_res predict_fraction(input logic [135:0] d);
        logic [2:0]  op;
        longint      an, ad, bn, bd, pa, pb;
        logic [63:0] anm, adm, bnm, bdm, rn, rd, g, l, t1, t2;
        logic        aneg, bneg, rneg, sb;
        logic        uses_b;
        t_res        r;
        op = d[2:0];
        an = longint'($signed(d[34:3]));
        ad = longint'($signed(d[66:35]));
        bn = longint'($signed(d[98:67]));
        bd = longint'($signed(d[130:99]));
        r  = '0;
        uses_b = (op <= rau_pkg::OP_DIV) || (op == rau_pkg::OP_CMP);
        if (ad == 0 || (uses_b && bd == 0) || (op == rau_pkg::OP_DIV && bn == 0) ||
            (op == rau_pkg::OP_REC && an == 0)) begin
            r.st = rau_pkg::ST_ZERO;
            return r;
        end
        if (op == rau_pkg::OP_CMP) begin
            if (ad < 0) begin an = -an; ad = -ad; end
            if (bd < 0) begin bn = -bn; bd = -bd; end
            pa = an * bd;
            pb = bn * ad;
            r.gt = pa > pb;
            r.lt = pa < pb;
            return r;
        end
        anm = abs64(an); adm = abs64(ad); bnm = abs64(bn); bdm = abs64(bd);
        aneg = (an != 0) && ((an < 0) != (ad < 0));
        bneg = (bn != 0) && ((bn < 0) != (bd < 0));
        rn = anm; rd = adm; rneg = aneg;
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                l  = adm / gcd64(adm, bdm) * bdm;
                t1 = anm * (l / adm);
                t2 = bnm * (l / bdm);
                sb = (op == rau_pkg::OP_SUB) ? !bneg : bneg;
                if (bnm == 0) sb = 1'b0;
                if (aneg == sb) begin
                    rneg = aneg; rn = t1 + t2;
                end else if (t1 >= t2) begin
                    rneg = aneg; rn = t1 - t2;
                end else begin
                    rneg = sb; rn = t2 - t1;
                end
                rd = l;
            end
            rau_pkg::OP_MUL: begin
                rn = anm * bnm; rd = adm * bdm; rneg = aneg != bneg;
            end
            rau_pkg::OP_DIV: begin
                rn = anm * bdm; rd = adm * bnm; rneg = aneg != bneg;
            end
            rau_pkg::OP_REC: begin
                rn = adm; rd = anm;
            end
            default: ;
        endcase
        if (rn == 0) begin
            rneg = 1'b0;
            rd = 1;
        end else begin
            g = gcd64(rn, rd);
            rn = rn / g;
            rd = rd / g;
        end
        if (rd > rau_pkg::LIM - 1 || rn > (rneg ? rau_pkg::LIM : rau_pkg::LIM - 1)) begin
            r.st = rau_pkg::ST_OVF;
            return r;
        end
        r.num = rneg ? 32'(-rn) : rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(predict_fraction(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.num = i_m_tdata[31:0];
                got.den = i_m_tdata[62:32];
                got.gt  = i_m_tdata[63];
                got.lt  = i_m_tdata[64];
                got.st  = i_m_tdata[66:65];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata[31:0], 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
                    if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
                    if (got.gt !== want.gt) report_mismatch("is_greater", got.gt, want.gt);
                    if (got.lt !== want.lt) report_mismatch("is_less", got.lt, want.lt);
                    if (got.st !== want.st) report_mismatch("status", got.st, want.st);
                end
            end
            o_pending = expected_q.size();
        end
    end

    initial o_pending = 0;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus for the rational arithmetic unit
// Drives directed corner requests and random fractions through four phases
// of varied sender idling and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;  // opcode, a_num, a_den, b_num, b_den
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;       // res_num, res_den, is_greater, is_less, status
    int           errors, pending;
    int           send_idle = 0, recv_stall = 0;
    longint       cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rational_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    rau_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'($signed($urandom_range(20)) - 10);
            1: return {1'b1, 31'b0};
            2: return 32'h7fffffff;
            3: return $urandom;
            4: return 32'($urandom_range(1000)) * (($urandom_range(1)) ? 1 : -1);
            5: return 32'($urandom_range(65535)) - 32768;
            default: return 32'($urandom_range(200)) - 100;
        endcase
    endfunction

    // The valid line is left high after an accepted request; an idle gap
    // or the end of a phase drops it.
    task automatic send_request(input logic [2:0] op, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, bd, bn, ad, an, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] v[4];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed corners: every operation, zero denominators and divisors, the
        // extremes of a_num, a_den and b_num, overflow and the unused opcode.
        for (int op = 0; op < 8; op++)
            send_request(3'(op), 32'd3, -32'sd4, -32'sd5, 32'd6);
        send_request(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
        send_request(rau_pkg::OP_MUL, 32'd1, 32'd2, 32'd1, 32'd0);
        send_request(rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
        send_request(rau_pkg::OP_REC, 32'd0, 32'd7, 32'd0, 32'd0);
        send_request(rau_pkg::OP_RED, 32'h80000000, 32'hffffffff, 32'd0, 32'd0);
        send_request(rau_pkg::OP_MUL, 32'h7fffffff, 32'd1, 32'h7fffffff, 32'd1);
        send_request(rau_pkg::OP_ADD, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h7ffffffe);
        send_request(rau_pkg::OP_SUB, 32'd5, 32'd9, 32'd5, 32'd9);
        send_request(rau_pkg::OP_CMP, 32'hffffffff, 32'h80000000,
                     32'h7fffffff, 32'hffffffff);
        send_request(rau_pkg::OP_DIV, 32'h80000000, 32'd1, 32'hffffffff, 32'd1);
        send_request(rau_pkg::OP_REC, 32'hffffffff, 32'h80000000, 32'd0, 32'd0);
        send_request(rau_pkg::OP_CMP, 32'd1, 32'd0, 32'd1, 32'd1);
        for (int phase = 0; phase < 4; phase++) begin
            send_idle  = (phase == 1 || phase == 3) ? (phase == 1 ? 48 : 27) : 0;
            recv_stall = (phase >= 2) ? (phase == 2 ? 48 : 27) : 0;
            for (int n = 0; n < 400; n++) begin
                foreach (v[k]) v[k] = pick_value();
                send_request(3'($urandom_range(7)), v[0], v[1], v[2], v[3]);
            end
            // Hold the sender back until every result has drained.
            s_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
        end
        repeat (500) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
